// ----- hw/rtl/itpom_pkg.sv -----
package itpom_pkg;

  // Sizes of the stores and fields.
  localparam int unsigned MAX_PARTS   = 256;
  localparam int unsigned PART_AW     = 8;
  localparam int unsigned OWNER_DEPTH = 4096;
  localparam int unsigned OWNER_AW    = 12;
  localparam int unsigned IDX_W       = 32;
  localparam int unsigned CNT_W       = 32;
  localparam int unsigned PCNT_W      = 9;
  localparam int unsigned MODE_W      = 3;
  localparam int unsigned CFG_AW      = 4;

  // Operation codes.
  localparam logic [1:0] OP_MAP   = 2'd0;
  localparam logic [1:0] OP_LDSZ  = 2'd1;
  localparam logic [1:0] OP_LDOWN = 2'd2;
  localparam logic [1:0] OP_CLR   = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_RANGE  = 2'd1;
  localparam logic [1:0] ST_CONFIG = 2'd2;
  localparam logic [1:0] ST_NOPART = 2'd3;

  // Mapping modes.
  localparam logic [2:0] MD_CYCLIC  = 3'd0;
  localparam logic [2:0] MD_SIZETAB = 3'd1;
  localparam logic [2:0] MD_UNIFORM = 3'd2;
  localparam logic [2:0] MD_BLKCYC  = 3'd3;
  localparam logic [2:0] MD_OWNER   = 3'd4;

  // Register indexes (byte address bits [3:2]).
  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_SIZE  = 2'd1;
  localparam logic [1:0] REG_PCNT  = 2'd2;
  localparam logic [1:0] REG_BLEN  = 2'd3;

  typedef struct packed {
    logic [1:0]       operation;
    logic [IDX_W-1:0] element_index;
    logic [31:0]      entry_value;
  } in_t;

  typedef struct packed {
    logic [7:0]       part;
    logic [CNT_W-1:0] part_tally;
    logic [1:0]       status;
  } out_t;

endpackage

// ----- hw/rtl/itpom_ram.sv -----
module itpom_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/itpom_div.sv -----
module itpom_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quo,
  output logic [31:0] rem
);

  logic [31:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [31:0] dvs_r;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        run_r, run_nxt;
  logic        done_r, done_nxt;
  logic [32:0] trial;

  // One restoring step per cycle: shift in the next dividend bit and try the subtract.
  always_comb begin
    trial    = {rem_r, quo_r[31]} - {1'b0, dvs_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = '0;
      quo_nxt = dividend;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (!trial[32]) begin
        rem_nxt = trial[31:0];
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[30:0], quo_r[31]};
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd31) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

// ----- hw/rtl/index_to_part_owner_mapper_core.sv -----
// Flow: loads and clears finish straight from idle; cyclic map uses one divider pass;
// uniform block and block-cyclic use two passes of the bit-serial divider; owner table
// and size table maps read and check table entries, one entry per part visited in a walk.
// One item at a time; busy stays high until the result strobe. The receiver cannot stall.
// Reset (rst_n, synchronous): registers to mode 0, set_size 0, part_count 1,
// block_len 1; counters read as zero through per-entry valid bits.
module index_to_part_owner_mapper_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  itpom_pkg::in_t                       in_item,
  output logic                                 out_valid,
  output itpom_pkg::out_t                      out_item,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [itpom_pkg::CFG_AW-1:0]         paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_DIV  = 9'b000000010,
    S_WRD  = 9'b000000100,
    S_WCHK = 9'b000001000,
    S_ORD  = 9'b000010000,
    S_OCHK = 9'b000100000,
    S_CRD  = 9'b001000000,
    S_CWR  = 9'b010000000,
    S_DIV2 = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic [itpom_pkg::MODE_W-1:0] mode_r;
  logic [31:0]                  size_r;
  logic [itpom_pkg::PCNT_W-1:0] pcnt_r;
  logic [31:0]                  blen_r;

  logic [31:0]                     x_r, x_nxt;
  logic [itpom_pkg::PCNT_W-1:0]    wp_r, wp_nxt;
  logic [itpom_pkg::PART_AW-1:0]   p_r, p_nxt;
  logic [itpom_pkg::MAX_PARTS-1:0] vld_r, vld_nxt;
  logic                            ov_r, ov_nxt;
  itpom_pkg::out_t                 out_r, out_nxt;

  logic        div_start, div_done;
  logic [31:0] div_a, div_b, div_q, div_rem;

  logic                                sz_we, own_we, cnt_we;
  logic [31:0]                         sz_rdata, cnt_rdata, cnt_wdata, cnt_cur;
  logic [7:0]                          own_rdata;
  logic [itpom_pkg::OWNER_AW-1:0]      own_raddr;
  logic [itpom_pkg::PART_AW-1:0]       sz_raddr;

  logic        cfg_bad, cfg_we;
  logic [31:0] pcnt_ext;

  assign pcnt_ext = {{(32 - itpom_pkg::PCNT_W){1'b0}}, pcnt_r};

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= itpom_pkg::MD_CYCLIC;
      size_r <= '0;
      pcnt_r <= itpom_pkg::PCNT_W'(1);
      blen_r <= 32'd1;
    end else if (cfg_we) begin
      case (paddr[3:2])
        itpom_pkg::REG_MODE: mode_r <= pwdata[itpom_pkg::MODE_W-1:0];
        itpom_pkg::REG_SIZE: size_r <= pwdata;
        itpom_pkg::REG_PCNT: pcnt_r <= pwdata[itpom_pkg::PCNT_W-1:0];
        itpom_pkg::REG_BLEN: blen_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      itpom_pkg::REG_MODE: prdata = {{(32 - itpom_pkg::MODE_W){1'b0}}, mode_r};
      itpom_pkg::REG_SIZE: prdata = size_r;
      itpom_pkg::REG_PCNT: prdata = pcnt_ext;
      itpom_pkg::REG_BLEN: prdata = blen_r;
      default:             prdata = '0;
    endcase
  end

  // Configuration sanity check for map requests.
  assign cfg_bad = (mode_r > itpom_pkg::MD_OWNER) || (pcnt_r == '0) ||
                   (pcnt_r > itpom_pkg::PCNT_W'(itpom_pkg::MAX_PARTS)) ||
                   (mode_r == itpom_pkg::MD_BLKCYC && blen_r == '0) ||
                   (mode_r == itpom_pkg::MD_UNIFORM && size_r == '0);

  // Counter value as stored, or zero if cleared since last write.
  assign cnt_cur   = vld_r[p_r] ? cnt_rdata : '0;
  assign cnt_wdata = (cnt_cur == '1) ? cnt_cur : cnt_cur + 32'd1;

  // Main sequencer.
  always_comb begin
    state_nxt = state_r;
    x_nxt     = x_r;
    wp_nxt    = wp_r;
    p_nxt     = p_r;
    vld_nxt   = vld_r;
    ov_nxt    = 1'b0;
    out_nxt   = out_r;
    div_start = 1'b0;
    div_a     = x_r;
    div_b     = pcnt_ext;
    sz_we     = 1'b0;
    own_we    = 1'b0;
    cnt_we    = 1'b0;
    sz_raddr  = wp_r[itpom_pkg::PART_AW-1:0];
    own_raddr = x_r[itpom_pkg::OWNER_AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (start) begin
          out_nxt = '0;
          x_nxt   = in_item.element_index;
          case (in_item.operation)
            itpom_pkg::OP_MAP: begin
              if (cfg_bad) begin
                out_nxt.status = itpom_pkg::ST_CONFIG;
                ov_nxt         = 1'b1;
              end else if (in_item.element_index >= size_r) begin
                out_nxt.status = itpom_pkg::ST_RANGE;
                ov_nxt         = 1'b1;
              end else begin
                case (mode_r)
                  itpom_pkg::MD_CYCLIC: begin
                    div_start = 1'b1;
                    div_a     = in_item.element_index;
                    state_nxt = S_DIV;
                  end
                  itpom_pkg::MD_SIZETAB: begin
                    wp_nxt    = '0;
                    state_nxt = S_WRD;
                  end
                  itpom_pkg::MD_UNIFORM: begin
                    // Block size is ((set_size - 1) / parts) + 1.
                    div_start = 1'b1;
                    div_a     = size_r - 32'd1;
                    state_nxt = S_DIV;
                  end
                  itpom_pkg::MD_BLKCYC: begin
                    div_start = 1'b1;
                    div_a     = in_item.element_index;
                    div_b     = blen_r;
                    state_nxt = S_DIV;
                  end
                  default: begin
                    if (in_item.element_index >= 32'(itpom_pkg::OWNER_DEPTH)) begin
                      out_nxt.status = itpom_pkg::ST_NOPART;
                      ov_nxt         = 1'b1;
                    end else begin
                      state_nxt = S_ORD;
                    end
                  end
                endcase
              end
            end
            itpom_pkg::OP_LDSZ: begin
              if (in_item.element_index < 32'(itpom_pkg::MAX_PARTS)) begin
                sz_we = 1'b1;
              end else begin
                out_nxt.status = itpom_pkg::ST_RANGE;
              end
              ov_nxt = 1'b1;
            end
            itpom_pkg::OP_LDOWN: begin
              if (in_item.element_index < 32'(itpom_pkg::OWNER_DEPTH)) begin
                own_we = 1'b1;
              end else begin
                out_nxt.status = itpom_pkg::ST_RANGE;
              end
              ov_nxt = 1'b1;
            end
            default: begin
              vld_nxt = '0;
              ov_nxt  = 1'b1;
            end
          endcase
        end
      end

      // First divider pass.
      S_DIV: begin
        if (div_done) begin
          case (mode_r)
            itpom_pkg::MD_CYCLIC: begin
              p_nxt     = div_rem[itpom_pkg::PART_AW-1:0];
              state_nxt = S_CRD;
            end
            itpom_pkg::MD_UNIFORM: begin
              div_start = 1'b1;
              div_a     = x_r;
              div_b     = div_q + 32'd1;
              state_nxt = S_DIV2;
            end
            default: begin
              div_start = 1'b1;
              div_a     = div_q;
              div_b     = pcnt_ext;
              state_nxt = S_DIV2;
            end
          endcase
        end
      end

      // Second divider pass.
      S_DIV2: begin
        if (div_done) begin
          if (mode_r == itpom_pkg::MD_UNIFORM) begin
            p_nxt = div_q[itpom_pkg::PART_AW-1:0];
          end else begin
            p_nxt = div_rem[itpom_pkg::PART_AW-1:0];
          end
          state_nxt = S_CRD;
        end
      end

      // Size table walk: read one entry, then subtract or stop.
      S_WRD: begin
        state_nxt = S_WCHK;
      end

      S_WCHK: begin
        if (x_r >= sz_rdata) begin
          x_nxt  = x_r - sz_rdata;
          wp_nxt = wp_r + itpom_pkg::PCNT_W'(1);
          if (wp_nxt >= pcnt_r) begin
            out_nxt.status = itpom_pkg::ST_NOPART;
            ov_nxt         = 1'b1;
            state_nxt      = S_IDLE;
          end else begin
            state_nxt = S_WRD;
          end
        end else begin
          p_nxt     = wp_r[itpom_pkg::PART_AW-1:0];
          state_nxt = S_CRD;
        end
      end

      // Owner table lookup.
      S_ORD: begin
        state_nxt = S_OCHK;
      end

      S_OCHK: begin
        if ({1'b0, own_rdata} >= pcnt_r) begin
          out_nxt.status = itpom_pkg::ST_NOPART;
          ov_nxt         = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          p_nxt     = own_rdata;
          state_nxt = S_CRD;
        end
      end

      // Counter read, then saturating increment and write back.
      S_CRD: begin
        state_nxt = S_CWR;
      end

      S_CWR: begin
        cnt_we             = 1'b1;
        vld_nxt[p_r]       = 1'b1;
        out_nxt.part       = p_r;
        out_nxt.part_tally = cnt_wdata;
        out_nxt.status     = itpom_pkg::ST_OK;
        ov_nxt             = 1'b1;
        state_nxt          = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      vld_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      vld_r   <= vld_nxt;
      ov_r    <= ov_nxt;
    end
    x_r   <= x_nxt;
    wp_r  <= wp_nxt;
    p_r   <= p_nxt;
    out_r <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_item  = out_r;

  itpom_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quo      (div_q),
    .rem      (div_rem)
  );

  itpom_ram #(.WIDTH(32), .DEPTH(itpom_pkg::MAX_PARTS)) u_size_ram (
    .clk   (clk),
    .we    (sz_we),
    .waddr (in_item.element_index[itpom_pkg::PART_AW-1:0]),
    .wdata (in_item.entry_value),
    .raddr (sz_raddr),
    .rdata (sz_rdata)
  );

  itpom_ram #(.WIDTH(8), .DEPTH(itpom_pkg::OWNER_DEPTH)) u_owner_ram (
    .clk   (clk),
    .we    (own_we),
    .waddr (in_item.element_index[itpom_pkg::OWNER_AW-1:0]),
    .wdata (in_item.entry_value[7:0]),
    .raddr (own_raddr),
    .rdata (own_rdata)
  );

  itpom_ram #(.WIDTH(itpom_pkg::CNT_W), .DEPTH(itpom_pkg::MAX_PARTS)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (p_r),
    .wdata (cnt_wdata),
    .raddr (p_r),
    .rdata (cnt_rdata)
  );

endmodule

// ----- tb/sv/testbench.sv -----
module testbench;
  import itpom_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_t         in_item = '0;
  logic        out_valid;
  out_t        out_item;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  index_to_part_owner_mapper_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  // Shadow copy of the registers and stores.
  logic [MODE_W-1:0] cur_mode;
  logic [31:0]       cur_set_size;
  logic [PCNT_W-1:0] cur_part_count;
  logic [31:0]       cur_block_len;
  logic [31:0]       tally_store [MAX_PARTS];
  logic [31:0]       size_store [MAX_PARTS];
  logic [7:0]        owner_store [OWNER_DEPTH];
  bit                owner_written [OWNER_DEPTH];
  int unsigned       owner_slots[$];

  out_t        expected_results[$];
  int          fail_count = 0;
  int          items_sent = 0;
  int          results_seen = 0;
  int unsigned status_hits [4];

  // True when the configuration is good for the current mode.
  function automatic bit config_good();
    if (cur_mode > MD_OWNER || cur_part_count == 0 || cur_part_count > MAX_PARTS) return 0;
    if (cur_mode == MD_BLKCYC && cur_block_len == 0) return 0;
    if (cur_mode == MD_UNIFORM && cur_set_size == 0) return 0;
    return 1;
  endfunction

  // A map that would look up an owner slot that was never loaded.
  function automatic bit hits_unloaded_owner(logic [31:0] idx);
    return config_good() && cur_mode == MD_OWNER && idx < cur_set_size &&
           idx < OWNER_DEPTH && !owner_written[idx];
  endfunction

  // Computes the result of one item and updates the shadow state.
  function automatic out_t predict_mapping(in_t it);
    out_t r;
    longint unsigned x, n, sz, p, blk;
    logic [1:0] st;
    r  = '0;
    st = ST_OK;
    x  = it.element_index;
    n  = cur_part_count;
    sz = cur_set_size;
    p  = 0;
    case (it.operation)
      OP_MAP: begin
        if (!config_good()) st = ST_CONFIG;
        else if (x >= sz) st = ST_RANGE;
        else begin
          case (cur_mode)
            MD_CYCLIC: p = x % n;
            MD_SIZETAB: begin
              while (p < n && x >= size_store[p]) begin
                x = x - size_store[p];
                p++;
              end
              if (p >= n) st = ST_NOPART;
            end
            MD_UNIFORM: begin
              blk = (sz + n - 1) / n;
              p = x / blk;
            end
            MD_BLKCYC: p = (x / cur_block_len) % n;
            default: begin
              if (x >= OWNER_DEPTH) st = ST_NOPART;
              else begin
                p = owner_store[x];
                if (p >= n) st = ST_NOPART;
              end
            end
          endcase
        end
        if (st == ST_OK) begin
          if (tally_store[p] != 32'hFFFF_FFFF) tally_store[p] = tally_store[p] + 1;
          r.part = p[7:0];
          r.part_tally = tally_store[p];
        end
      end
      OP_LDSZ: begin
        if (x < MAX_PARTS) size_store[x] = it.entry_value;
        else st = ST_RANGE;
      end
      OP_LDOWN: begin
        if (x < OWNER_DEPTH) begin
          owner_store[x] = it.entry_value[7:0];
          if (!owner_written[x]) owner_slots.push_back(x);
          owner_written[x] = 1;
        end else st = ST_RANGE;
      end
      default: begin
        for (int i = 0; i < MAX_PARTS; i++) tally_store[i] = '0;
      end
    endcase
    r.status = st;
    return r;
  endfunction

  // Sends one item after a random gap; start is left high on return.
  task automatic send_item(logic [1:0] op, logic [31:0] idx, logic [31:0] val);
    in_t it;
    int  gap;
    gap = $urandom_range(0, 10);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    it.operation = op;
    it.element_index = idx;
    it.entry_value = val;
    in_item = it;
    start = 1'b1;
    while (busy) @(negedge clk);
    // The item is taken at the coming rising edge.
    expected_results.push_back(predict_mapping(it));
    items_sent++;
    @(negedge clk);
  endtask

  // Writes one register while the block is idle.
  task automatic write_reg(logic [1:0] regno, logic [31:0] value);
    start = 1'b0;
    wait (expected_results.size() == 0);
    repeat (4) @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {regno, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    case (regno)
      REG_MODE: cur_mode = value[MODE_W-1:0];
      REG_SIZE: cur_set_size = value;
      REG_PCNT: cur_part_count = value[PCNT_W-1:0];
      default:  cur_block_len = value;
    endcase
  endtask

  task automatic configure(logic [2:0] m, logic [31:0] sz, logic [8:0] pc, logic [31:0] bl);
    write_reg(REG_MODE, {29'd0, m});
    write_reg(REG_SIZE, sz);
    write_reg(REG_PCNT, {23'd0, pc});
    write_reg(REG_BLEN, bl);
  endtask

  // Picks an index: anywhere, near zero, around the set boundary or inside it.
  function automatic logic [31:0] pick_index();
    logic [31:0] idx;
    case ($urandom_range(0, 5))
      0: idx = $urandom;
      1: idx = $urandom_range(0, 40);
      2: idx = cur_set_size + $urandom_range(0, 6) - 3;
      default: idx = (cur_set_size == 0) ? $urandom : $urandom % cur_set_size;
    endcase
    return idx;
  endfunction

  // Checks each result against the oldest expectation.
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid) begin
      results_seen++;
      status_hits[out_item.status]++;
      if (expected_results.size() == 0) begin
        $error("result with no item outstanding: part %0d tally %0d status %0d",
               out_item.part, out_item.part_tally, out_item.status);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_item.part !== want.part) begin
          $error("part: expected %0d, got %0d", want.part, out_item.part);
          fail_count++;
        end
        if (out_item.part_tally !== want.part_tally) begin
          $error("part_tally: expected %0d, got %0d", want.part_tally, out_item.part_tally);
          fail_count++;
        end
        if (out_item.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_item.status);
          fail_count++;
        end
      end
    end
  end

  // Reset values, configuration errors, load range checks and clearing.
  task automatic test_directed();
    send_item(OP_MAP, 32'd0, 32'd0);
    send_item(OP_LDSZ, 32'd256, 32'hFFFF_FFFF);
    send_item(OP_LDSZ, 32'hFFFF_FFFF, 32'd1);
    send_item(OP_LDOWN, 32'd4096, 32'd1);
    send_item(OP_LDOWN, 32'd0, 32'hFFFF_FF02);
    send_item(OP_LDOWN, 32'd4095, 32'd1);
    configure(MD_CYCLIC, 32'hFFFF_FFFF, 9'd256, 32'd1);
    send_item(OP_MAP, 32'hFFFF_FFFE, 32'd0);
    send_item(OP_MAP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_MAP, 32'd256, 32'd0);
    send_item(OP_CLR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_MAP, 32'd0, 32'd0);
    configure(3'd7, 32'd100, 9'd4, 32'd1);
    send_item(OP_MAP, 32'd1, 32'd0);
    configure(MD_CYCLIC, 32'd100, 9'd0, 32'd1);
    send_item(OP_MAP, 32'd1, 32'd0);
    configure(MD_CYCLIC, 32'd100, 9'd257, 32'd1);
    send_item(OP_MAP, 32'd1, 32'd0);
    configure(MD_BLKCYC, 32'd100, 9'd4, 32'd0);
    send_item(OP_MAP, 32'd500, 32'd0);
    configure(MD_UNIFORM, 32'd0, 9'd4, 32'd1);
    send_item(OP_MAP, 32'd0, 32'd0);
    configure(MD_OWNER, 32'd8000, 9'd2, 32'd1);
    send_item(OP_MAP, 32'd0, 32'd0);
    send_item(OP_MAP, 32'd4095, 32'd0);
    send_item(OP_MAP, 32'd4096, 32'd0);
    start = 1'b0;
  endtask

  // Fills the whole size table so that walks never meet an unloaded entry, then loads 64 random owner slots.
  task automatic test_size_table_fill();
    for (int i = 0; i < MAX_PARTS; i++)
      send_item(OP_LDSZ, i, (i % 64 == 5) ? 32'd0 : $urandom_range(1, 40));
    for (int i = 0; i < 64; i++)
      send_item(OP_LDOWN, $urandom_range(0, OWNER_DEPTH - 1), $urandom);
    start = 1'b0;
  endtask

  // One setting, then a random mix that is mostly mapping requests.
  task automatic test_random_phase(logic [2:0] m, logic [31:0] sz, logic [8:0] pc,
                                   logic [31:0] bl, int count);
    logic [31:0] idx;
    logic [31:0] val;
    int          sel;
    configure(m, sz, pc, bl);
    for (int k = 0; k < count; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 76) begin
        idx = pick_index();
        if (hits_unloaded_owner(idx))
          idx = owner_slots[$urandom_range(0, owner_slots.size() - 1)];
        send_item(OP_MAP, idx, $urandom);
      end else if (sel < 86) begin
        idx = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, MAX_PARTS - 1);
        val = ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 40);
        send_item(OP_LDSZ, idx, val);
      end else if (sel < 96) begin
        idx = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, OWNER_DEPTH - 1);
        val = $urandom;
        if ($urandom_range(0, 1)) val[7:0] = $urandom_range(0, 9);
        send_item(OP_LDOWN, idx, val);
      end else begin
        send_item(OP_CLR, $urandom, $urandom);
      end
    end
    start = 1'b0;
  endtask

  // Run limit.
  initial begin
    #40000000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    cur_mode = MD_CYCLIC;
    cur_set_size = '0;
    cur_part_count = 9'd1;
    cur_block_len = 32'd1;
    for (int i = 0; i < MAX_PARTS; i++) begin
      tally_store[i] = '0;
      size_store[i] = '0;
    end
    for (int i = 0; i < OWNER_DEPTH; i++) begin
      owner_store[i] = '0;
      owner_written[i] = 0;
    end
    for (int i = 0; i < 4; i++) status_hits[i] = 0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_size_table_fill();
    test_random_phase(MD_CYCLIC, 32'd1000, 9'd7, 32'd1, 60);
    test_random_phase(MD_CYCLIC, 32'hFFFF_FFFF, 9'd256, 32'd1, 50);
    test_random_phase(MD_SIZETAB, 32'd6000, 9'd256, 32'd1, 60);
    test_random_phase(MD_SIZETAB, 32'd200, 9'd5, 32'd1, 50);
    test_random_phase(MD_UNIFORM, 32'hFFFF_FFFF, 9'd256, 32'd1, 50);
    test_random_phase(MD_UNIFORM, 32'd10, 9'd3, 32'd1, 40);
    test_random_phase(MD_UNIFORM, $urandom, $urandom_range(1, 256), 32'd1, 40);
    test_random_phase(MD_BLKCYC, 32'hFFFF_FFFF, 9'd256, 32'hFFFF_FFFF, 40);
    test_random_phase(MD_BLKCYC, 32'd5000, 9'd3, 32'd1, 40);
    test_random_phase(MD_BLKCYC, $urandom, $urandom_range(1, 256), $urandom_range(1, 99), 50);
    test_random_phase(MD_BLKCYC, $urandom, 9'd1, $urandom, 30);
    test_random_phase(MD_OWNER, 32'd5000, 9'd200, 32'd1, 60);
    test_random_phase(MD_OWNER, 32'd4096, 9'd10, 32'd1, 50);
    test_random_phase(MD_OWNER, 32'hFFFF_FFFF, 9'd256, 32'd1, 30);
    test_random_phase(3'd5 + $urandom_range(0, 2), 32'd100, 9'd4, 32'd3, 20);
    test_random_phase(MD_CYCLIC, 32'd300, 9'd0, 32'd1, 20);
    test_random_phase(MD_CYCLIC, 32'd300, 9'd257 + $urandom_range(0, 254), 32'd1, 20);
    test_random_phase(MD_CYCLIC, $urandom, $urandom_range(1, 256), 32'd1, 40);
    test_random_phase(MD_SIZETAB, $urandom_range(0, 9000), $urandom_range(1, 256), 32'd1, 40);

    start = 1'b0;
    wait (expected_results.size() == 0);
    repeat (600) @(posedge clk);
    if (expected_results.size() != 0) fail_count++;
    $display("Sent %0d items over all five modes and the error cases; %0d results checked.",
             items_sent, results_seen);
    $display("Status counts: ok %0d, range %0d, config %0d, no part %0d.",
             status_hits[0], status_hits[1], status_hits[2], status_hits[3]);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
